### sv/axp_pkg.sv
// shared types, constants and helper functions for the ax.25 ui frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package axp_pkg;

    // payload byte counter width, counter saturates at all ones
    localparam int LEN_BITS = 16;
    localparam int OUT_LEN_W = 16;

    // result queue between parser front and output back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CALL_CHARS = 6;
    localparam int CALL_W = 8 * CALL_CHARS;
    localparam int SSID_W = 4;
    localparam int TEXT_W = 7;

    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_MAX   = 7'd90;
    localparam logic [7:0] CTRL_UI    = 8'h03;
    localparam logic [7:0] PID_NONE   = 8'hF0;
    localparam logic [6:0] TEXT_DOT   = 7'd46;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [2:0] ADDR_LAST_BYTE = 3'd6;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_END    = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_DEST = 3'd0,
        PH_SRC  = 3'd1,
        PH_RPT  = 3'd2,
        PH_CTRL = 3'd3,
        PH_PID  = 3'd4,
        PH_PAY  = 3'd5,
        PH_SKIP = 3'd6
    } phase_t;

    // what one accepted byte asks the back end to emit
    typedef enum logic [2:0] {
        OP_HDR      = 3'd0,
        OP_HDR_END  = 3'd1,
        OP_TEXT     = 3'd2,
        OP_TEXT_END = 3'd3,
        OP_REJECT   = 3'd4
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CALL_W-1:0]    dest_call;
        logic [SSID_W-1:0]    dest_ssid;
        logic [CALL_W-1:0]    src_call;
        logic [SSID_W-1:0]    src_ssid;
        logic [TEXT_W-1:0]    text_char;
        logic [OUT_LEN_W-1:0] payload_len;
    } q_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    // shifted callsign char is kept if above space and up to 'Z'
    function automatic logic char_ok(input logic [7:0] b, input logic [2:0] kept);
        logic [6:0] c;
        c = b[7:1];
        return (c > CHAR_SPACE) && (c <= CHAR_MAX) && (kept < 3'(CALL_CHARS));
    endfunction

    // left-packed insert: first kept char lands in the top byte
    function automatic logic [CALL_W-1:0] char_ins(input logic [CALL_W-1:0] chars,
                                                   input logic [2:0] kept,
                                                   input logic [7:0] b);
        logic [CALL_W-1:0] r;
        r = chars;
        for (int i = 0; i < CALL_CHARS; i++) begin
            if (kept == 3'(CALL_CHARS - 1 - i)) begin
                r[8*i +: 8] = {1'b0, b[7:1]};
            end
        end
        return r;
    endfunction

    function automatic logic [TEXT_W-1:0] text_map(input logic [7:0] b);
        return (b inside {[PRINT_LO:PRINT_HI]}) ? b[6:0] : TEXT_DOT;
    endfunction

    function automatic logic [OUT_LEN_W-1:0] len_clamp(input logic [LEN_BITS-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'(17'h0FFFF)) ? '1 : w[OUT_LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/axp_front.sv
// parser front end: accepts frame bytes, walks the address field and
// pushes one queue entry per byte that yields results; uses axp_pkg
`default_nettype none

module axp_front
    import axp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_end,
    input  wire logic        q_ready,
    output logic             q_push,
    output q_entry_t         q_entry
);

    phase_t                phase_reg, phase_next;
    logic [2:0]            idx_reg, idx_next;
    logic [CALL_W-1:0]     dest_chars_reg, dest_chars_next;
    logic [2:0]            dest_kept_reg, dest_kept_next;
    logic [SSID_W-1:0]     dest_id_reg, dest_id_next;
    logic [CALL_W-1:0]     src_chars_reg, src_chars_next;
    logic [2:0]            src_kept_reg, src_kept_next;
    logic [SSID_W-1:0]     src_id_reg, src_id_next;
    logic [LEN_BITS-1:0]   count_reg, count_next;

    logic                  accept;
    logic [CALL_W-1:0]     dchars_v;
    logic [2:0]            dkept_v;
    logic [LEN_BITS-1:0]   count_inc;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    // first destination byte starts a fresh frame
    assign dchars_v  = (idx_reg == 3'd0) ? '0 : dest_chars_reg;
    assign dkept_v   = (idx_reg == 3'd0) ? 3'd0 : dest_kept_reg;
    assign count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DEST;
            idx_reg        <= '0;
            dest_chars_reg <= '0;
            dest_kept_reg  <= '0;
            dest_id_reg    <= '0;
            src_chars_reg  <= '0;
            src_kept_reg   <= '0;
            src_id_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            dest_chars_reg <= dest_chars_next;
            dest_kept_reg  <= dest_kept_next;
            dest_id_reg    <= dest_id_next;
            src_chars_reg  <= src_chars_next;
            src_kept_reg   <= src_kept_next;
            src_id_reg     <= src_id_next;
            count_reg      <= count_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        dest_chars_next = dest_chars_reg;
        dest_kept_next  = dest_kept_reg;
        dest_id_next    = dest_id_reg;
        src_chars_next  = src_chars_reg;
        src_kept_next   = src_kept_reg;
        src_id_next     = src_id_reg;
        count_next      = count_reg;

        q_push              = 1'b0;
        q_entry             = '0;
        q_entry.op          = OP_REJECT;
        q_entry.dest_call   = dest_chars_reg;
        q_entry.dest_ssid   = dest_id_reg;
        q_entry.src_call    = src_chars_reg;
        q_entry.src_ssid    = src_id_reg;
        q_entry.text_char   = text_map(in_byte);

        if (accept)
        begin
            case (phase_reg)
                PH_DEST:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        dest_id_next   = '0;
                        src_chars_next = '0;
                        src_kept_next  = '0;
                        src_id_next    = '0;
                        count_next     = '0;
                    end
                    dest_chars_next = dchars_v;
                    dest_kept_next  = dkept_v;
                    if (idx_reg < ADDR_LAST_BYTE)
                    begin
                        if (char_ok(in_byte, dkept_v))
                        begin
                            dest_chars_next = char_ins(dchars_v, dkept_v, in_byte);
                            dest_kept_next  = dkept_v + 3'd1;
                        end
                        idx_next = idx_reg + 3'd1;
                    end
                    else
                    begin
                        dest_id_next = in_byte[4:1];
                        phase_next   = PH_SRC;
                        idx_next     = '0;
                    end
                    if (in_end)
                    begin
                        q_push     = 1'b1;
                        phase_next = PH_DEST;
                        idx_next   = '0;
                    end
                end
                PH_SRC:
                begin
                    if (idx_reg < ADDR_LAST_BYTE)
                    begin
                        if (char_ok(in_byte, src_kept_reg))
                        begin
                            src_chars_next = char_ins(src_chars_reg, src_kept_reg, in_byte);
                            src_kept_next  = src_kept_reg + 3'd1;
                        end
                        idx_next = idx_reg + 3'd1;
                    end
                    else
                    begin
                        src_id_next = in_byte[4:1];
                        phase_next  = in_byte[0] ? PH_CTRL : PH_RPT;
                        idx_next    = '0;
                    end
                    if (in_end)
                    begin
                        q_push     = 1'b1;
                        phase_next = PH_DEST;
                        idx_next   = '0;
                    end
                end
                PH_RPT:
                begin
                    // repeater contents are ignored, only the end bit counts
                    if (idx_reg < ADDR_LAST_BYTE)
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                    else
                    begin
                        if (in_byte[0])
                        begin
                            phase_next = PH_CTRL;
                        end
                        idx_next = '0;
                    end
                    if (in_end)
                    begin
                        q_push     = 1'b1;
                        phase_next = PH_DEST;
                        idx_next   = '0;
                    end
                end
                PH_CTRL:
                begin
                    if (in_end || in_byte != CTRL_UI)
                    begin
                        q_push     = 1'b1;
                        phase_next = in_end ? PH_DEST : PH_SKIP;
                        idx_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_PID;
                    end
                end
                PH_PID:
                begin
                    q_push = 1'b1;
                    if (in_byte != PID_NONE)
                    begin
                        phase_next = in_end ? PH_DEST : PH_SKIP;
                        idx_next   = '0;
                    end
                    else
                    begin
                        count_next = '0;
                        if (in_end)
                        begin
                            q_entry.op = OP_HDR_END;
                            phase_next = PH_DEST;
                            idx_next   = '0;
                        end
                        else
                        begin
                            q_entry.op = OP_HDR;
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY:
                begin
                    q_push     = 1'b1;
                    count_next = count_inc;
                    q_entry.payload_len = len_clamp(count_inc);
                    if (in_end)
                    begin
                        q_entry.op = OP_TEXT_END;
                        phase_next = PH_DEST;
                        idx_next   = '0;
                    end
                    else
                    begin
                        q_entry.op = OP_TEXT;
                    end
                end
                PH_SKIP:
                begin
                    if (in_end)
                    begin
                        phase_next = PH_DEST;
                        idx_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_DEST;
                    idx_next   = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/axp_queue.sv
// short result queue between parser front and output back end
// register array with read and write pointers; uses axp_pkg
`default_nettype none

module axp_queue
    import axp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_ctl_t   ctl,
    input  wire q_entry_t wr_entry,
    output q_entry_t      rd_entry,
    output logic          not_empty,
    output logic          not_full
);

    q_entry_t            store [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != QCNT_W'(QDEPTH));
    assign rd_entry  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = ctl.push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = ctl.pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!ctl.push && ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            store[wr_ptr_reg] <= wr_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (not_full || ctl.pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

### sv/axp_back.sv
// output back end: pops queue entries and drives one result word per cycle
// while ready; two-result entries add an end-summary word; uses axp_pkg
`default_nettype none

module axp_back
    import axp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire q_entry_t          q_entry,
    input  wire logic              q_not_empty,
    output q_ctl_t                 pop_ctl,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output kind_t                  out_kind,
    output logic [CALL_W-1:0]      out_dest_call,
    output logic [SSID_W-1:0]      out_dest_ssid,
    output logic [CALL_W-1:0]      out_src_call,
    output logic [SSID_W-1:0]      out_src_ssid,
    output logic [TEXT_W-1:0]      out_text_char,
    output logic [OUT_LEN_W-1:0]   out_payload_len,
    output logic                   out_last
);

    logic                   valid_reg, valid_next;
    logic                   pend_reg, pend_next;
    logic [OUT_LEN_W-1:0]   pend_len_reg, pend_len_next;
    kind_t                  kind_reg, kind_next;
    logic [CALL_W-1:0]      dcall_reg, dcall_next;
    logic [SSID_W-1:0]      dssid_reg, dssid_next;
    logic [CALL_W-1:0]      scall_reg, scall_next;
    logic [SSID_W-1:0]      sssid_reg, sssid_next;
    logic [TEXT_W-1:0]      text_reg, text_next;
    logic [OUT_LEN_W-1:0]   len_reg, len_next;
    logic                   last_reg, last_next;

    logic fire;
    logic load_ok;
    logic pop;

    assign fire    = valid_reg && out_ready;
    assign load_ok = !valid_reg || (fire && !pend_reg);
    assign pop     = load_ok && q_not_empty;

    assign pop_ctl.push = 1'b0;
    assign pop_ctl.pop  = pop;

    always_comb
    begin
        valid_next    = valid_reg;
        pend_next     = pend_reg;
        pend_len_next = pend_len_reg;
        kind_next     = kind_reg;
        dcall_next    = dcall_reg;
        dssid_next    = dssid_reg;
        scall_next    = scall_reg;
        sssid_next    = sssid_reg;
        text_next     = text_reg;
        len_next      = len_reg;
        last_next     = last_reg;

        if (fire && pend_reg)
        begin
            // second word of a byte: frame end summary
            kind_next  = KIND_END;
            dcall_next = '0;
            dssid_next = '0;
            scall_next = '0;
            sssid_next = '0;
            text_next  = '0;
            len_next   = pend_len_reg;
            last_next  = 1'b1;
            pend_next  = 1'b0;
        end
        else if (pop)
        begin
            valid_next    = 1'b1;
            pend_len_next = q_entry.payload_len;
            dcall_next    = '0;
            dssid_next    = '0;
            scall_next    = '0;
            sssid_next    = '0;
            text_next     = '0;
            len_next      = '0;
            case (q_entry.op)
                OP_HDR, OP_HDR_END:
                begin
                    kind_next     = KIND_HEADER;
                    dcall_next    = q_entry.dest_call;
                    dssid_next    = q_entry.dest_ssid;
                    scall_next    = q_entry.src_call;
                    sssid_next    = q_entry.src_ssid;
                    last_next     = 1'b0;
                    pend_next     = (q_entry.op == OP_HDR_END);
                    pend_len_next = '0;
                end
                OP_TEXT, OP_TEXT_END:
                begin
                    kind_next = KIND_TEXT;
                    text_next = q_entry.text_char;
                    last_next = 1'b0;
                    pend_next = (q_entry.op == OP_TEXT_END);
                end
                default:
                begin
                    kind_next = KIND_REJECT;
                    last_next = 1'b1;
                    pend_next = 1'b0;
                end
            endcase
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_len_reg <= pend_len_next;
        kind_reg     <= kind_next;
        dcall_reg    <= dcall_next;
        dssid_reg    <= dssid_next;
        scall_reg    <= scall_next;
        sssid_reg    <= sssid_next;
        text_reg     <= text_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
    end

    assign out_valid       = valid_reg;
    assign out_kind        = kind_reg;
    assign out_dest_call   = dcall_reg;
    assign out_dest_ssid   = dssid_reg;
    assign out_src_call    = scall_reg;
    assign out_src_ssid    = sssid_reg;
    assign out_text_char   = text_reg;
    assign out_payload_len = len_reg;
    assign out_last        = last_reg;

    a_pend_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg)
        else $error("pending end summary with no word on output");

    a_pend_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (kind_reg == KIND_HEADER || kind_reg == KIND_TEXT))
        else $error("end summary pending behind a final word");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (last_reg == (kind_reg == KIND_END || kind_reg == KIND_REJECT)))
        else $error("last flag does not match result kind");

    a_no_pop_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && valid_reg) |-> !pop)
        else $error("queue popped while end summary pending");

endmodule

`default_nettype wire

### sv/ax25_ui_frame_parser.sv
// top level of the ax.25 ui frame parser: front parser, result queue and
// output back end; uses axp_pkg, axp_front, axp_queue, axp_back
`default_nettype none

// Takes one frame byte per word (tlast marks the final byte) and parses the
// destination, source and repeater addresses, control and pid. Output words
// are a header, one text char per payload byte, and an end summary with the
// saturating payload length; a short or malformed frame gives a reject word.
// Input accepts one byte per cycle while the queue has room. Each byte
// yields at most one output word, except the pid byte of an empty frame and
// the last payload byte, which yield two; the single output register sends
// those in turn, and a four-entry queue between the parser and the output
// stage absorbs this, so input stalls only when the output side is held
// off. A byte's first word passes the queue, then the output register. No
// clearing pass after reset.
module ax25_ui_frame_parser
    import axp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // data_byte[7:0]
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // dest_call[47:0], dest_ssid[51:48], src_call[99:52], src_ssid[103:100],
    // text_char[110:104], payload_len[126:111], zero pad[127]
    output logic [127:0]       m_axis_tdata,
    output logic [1:0]         m_axis_tuser,   // kind[1:0]
    output logic               m_axis_tlast
);

    q_entry_t               push_entry;
    q_entry_t               head_entry;
    logic                   push;
    logic                   q_not_empty;
    logic                   q_not_full;
    q_ctl_t                 back_ctl;
    q_ctl_t                 q_ctl;
    kind_t                  kind;
    logic [CALL_W-1:0]      dest_call;
    logic [SSID_W-1:0]      dest_ssid;
    logic [CALL_W-1:0]      src_call;
    logic [SSID_W-1:0]      src_ssid;
    logic [TEXT_W-1:0]      text_char;
    logic [OUT_LEN_W-1:0]   payload_len;

    axp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_end   (s_axis_tlast),
        .q_ready  (q_not_full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    assign q_ctl.push = push;
    assign q_ctl.pop  = back_ctl.pop;

    axp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .wr_entry  (push_entry),
        .rd_entry  (head_entry),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    axp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_entry         (head_entry),
        .q_not_empty     (q_not_empty),
        .pop_ctl         (back_ctl),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_kind        (kind),
        .out_dest_call   (dest_call),
        .out_dest_ssid   (dest_ssid),
        .out_src_call    (src_call),
        .out_src_ssid    (src_ssid),
        .out_text_char   (text_char),
        .out_payload_len (payload_len),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, payload_len, text_char, src_ssid, src_call,
                           dest_ssid, dest_call};
    assign m_axis_tuser = kind;

endmodule

`default_nettype wire

### dv/ax25_ui_frame_parser_sb.sv
// scoreboard for the ax.25 ui frame parser bench: predicts the output words
// from each accepted frame byte and checks the words the block sends
// depends on axp_pkg for the kind and phase codes and field widths
`timescale 1ns / 1ps

package ax25_ui_frame_sb_pkg;
    import axp_pkg::*;

    localparam int ADDR_DEST = 0;
    localparam int ADDR_SRC  = 1;
    localparam int LEN_OUT_MAX = 65535;

    typedef struct {
        kind_t                kind;
        logic [CALL_W-1:0]    dest_call;
        logic [SSID_W-1:0]    dest_ssid;
        logic [CALL_W-1:0]    src_call;
        logic [SSID_W-1:0]    src_ssid;
        logic [TEXT_W-1:0]    text_char;
        logic [OUT_LEN_W-1:0] payload_len;
        logic                 last;
    } frame_word_t;

    class ax25_word_checker;
        phase_t            ph;
        int unsigned       idx;
        logic [CALL_W-1:0] call [2];
        int unsigned       kept [2];
        logic [SSID_W-1:0] ssid [2];
        longint unsigned   pay_count;
        longint unsigned   len_max;
        frame_word_t       expected_words [$];
        int unsigned       errors;

        function new();
            len_max = (64'd1 << LEN_BITS) - 1;
            errors = 0;
            pay_count = 0;
            restart();
            for (int a = 0; a < 2; a++)
            begin
                call[a] = '0;
                kept[a] = 0;
                ssid[a] = '0;
            end
        endfunction

        function void restart();
            ph = PH_DEST;
            idx = 0;
        endfunction

        function void queue_word(frame_word_t w);
            expected_words.insert(expected_words.size(), w);
        endfunction

        function frame_word_t blank_word(kind_t k);
            frame_word_t w;
            w.kind = k;
            w.dest_call = '0;
            w.dest_ssid = '0;
            w.src_call = '0;
            w.src_ssid = '0;
            w.text_char = '0;
            w.payload_len = '0;
            w.last = (k == KIND_END) || (k == KIND_REJECT);
            return w;
        endfunction

        function void reject(bit fin);
            queue_word(blank_word(KIND_REJECT));
            if (fin)
            begin
                restart();
            end
            else
            begin
                ph = PH_SKIP;
            end
        endfunction

        // callsign chars are the byte shifted down, kept if above space up to 'Z'
        function void take_char(int a, logic [7:0] b);
            logic [6:0] c;
            c = b[7:1];
            if (c > CHAR_SPACE && c <= CHAR_MAX && kept[a] < CALL_CHARS)
            begin
                call[a][8 * (CALL_CHARS - 1 - kept[a]) +: 8] = {1'b0, c};
                kept[a]++;
            end
        endfunction

        function void note_byte(logic [7:0] b, bit fin);
            frame_word_t w;
            int          a;
            case (ph)
                PH_DEST, PH_SRC:
                begin
                    a = (ph == PH_SRC) ? ADDR_SRC : ADDR_DEST;
                    if (ph == PH_DEST && idx == 0)
                    begin
                        for (int i = 0; i < 2; i++)
                        begin
                            call[i] = '0;
                            kept[i] = 0;
                            ssid[i] = '0;
                        end
                        pay_count = 0;
                    end
                    if (idx < CALL_CHARS)
                    begin
                        take_char(a, b);
                        idx++;
                    end
                    else
                    begin
                        ssid[a] = b[4:1];
                        idx = 0;
                        if (a == ADDR_DEST)
                        begin
                            ph = PH_SRC;
                        end
                        else if (b[0])
                        begin
                            ph = PH_CTRL;
                        end
                        else
                        begin
                            ph = PH_RPT;
                        end
                    end
                    if (fin)
                    begin
                        reject(1'b1);
                    end
                end
                PH_RPT:
                begin
                    // repeater contents are ignored apart from the end bit
                    if (idx < CALL_CHARS)
                    begin
                        idx++;
                    end
                    else
                    begin
                        if (b[0])
                        begin
                            ph = PH_CTRL;
                        end
                        idx = 0;
                    end
                    if (fin)
                    begin
                        reject(1'b1);
                    end
                end
                PH_CTRL:
                begin
                    if (fin || b != CTRL_UI)
                    begin
                        reject(fin);
                    end
                    else
                    begin
                        ph = PH_PID;
                    end
                end
                PH_PID:
                begin
                    if (b != PID_NONE)
                    begin
                        reject(fin);
                    end
                    else
                    begin
                        w = blank_word(KIND_HEADER);
                        w.dest_call = call[ADDR_DEST];
                        w.dest_ssid = ssid[ADDR_DEST];
                        w.src_call = call[ADDR_SRC];
                        w.src_ssid = ssid[ADDR_SRC];
                        queue_word(w);
                        pay_count = 0;
                        if (fin)
                        begin
                            queue_word(blank_word(KIND_END));
                            restart();
                        end
                        else
                        begin
                            ph = PH_PAY;
                        end
                    end
                end
                PH_PAY:
                begin
                    w = blank_word(KIND_TEXT);
                    w.text_char = (b inside {[PRINT_LO:PRINT_HI]}) ? b[6:0] : TEXT_DOT;
                    queue_word(w);
                    if (pay_count < len_max)
                    begin
                        pay_count++;
                    end
                    if (fin)
                    begin
                        w = blank_word(KIND_END);
                        w.payload_len = (pay_count > LEN_OUT_MAX) ? OUT_LEN_W'(LEN_OUT_MAX)
                                                                  : pay_count[15:0];
                        queue_word(w);
                        restart();
                    end
                end
                default:
                begin
                    // bad control or pid: drop bytes up to the frame end
                    if (fin)
                    begin
                        restart();
                    end
                end
            endcase
        endfunction

        function void cmp_field(string name, longint unsigned exp_v, longint unsigned got_v);
            if (exp_v != got_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(logic [1:0] k, logic [127:0] d, logic l);
            frame_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: kind %0d, last %0d", k, l);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            cmp_field("kind", w.kind, k);
            cmp_field("dest_call", w.dest_call, d[47:0]);
            cmp_field("dest_ssid", w.dest_ssid, d[51:48]);
            cmp_field("src_call", w.src_call, d[99:52]);
            cmp_field("src_ssid", w.src_ssid, d[103:100]);
            cmp_field("text_char", w.text_char, d[110:104]);
            cmp_field("payload_len", w.payload_len, d[126:111]);
            cmp_field("last", w.last, l);
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

endpackage

### dv/ax25_ui_frame_parser_tb.sv
// top of the ax.25 ui frame parser bench: clock, reset, frame stimulus,
// random idling on both streams and the watchdog
// depends on axp_pkg, ax25_ui_frame_sb_pkg and the ax25_ui_frame_parser rtl
`timescale 1ns / 1ps

module ax25_ui_frame_parser_tb;
    import axp_pkg::*;
    import ax25_ui_frame_sb_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_BYTES = 600;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        FR_GOOD,
        FR_EMPTY,
        FR_CUT_RPT,
        FR_BAD_CTRL,
        FR_BAD_PID,
        FR_CTRL_END,
        FR_NOISE,
        FR_CUT_ANY
    } frame_kind_t;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;

    ax25_word_checker sb;
    logic [7:0]       frame_buf [$];
    int               bytes_sent;
    int               stall_cycles = 0;
    bit               quiet;
    bit               hold_req;
    bit               hold_done;

    ax25_ui_frame_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // one byte per call; random gaps before it unless in a quiet stretch
    task automatic send_word(logic [7:0] b, bit fin);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_frame(int n);
        for (int i = 0; i < n; i++)
        begin
            send_word(frame_buf[i], i == n - 1);
        end
    endtask

    function automatic void add_byte(logic [7:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endfunction

    function automatic logic [7:0] bad_byte(logic [7:0] good);
        logic [7:0] r;
        do
        begin
            r = 8'($urandom);
        end
        while (r == good);
        return r;
    endfunction

    // mostly plausible callsign chars, some raw bytes to exercise the filter
    function automatic void add_addr(bit end_bit);
        string call_set;
        int    k;
        byte   ch;
        call_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 ";
        for (int i = 0; i < CALL_CHARS; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, call_set.len() - 1);
                ch = call_set[k];
                add_byte({ch[6:0], 1'b0});
            end
            else
            begin
                add_byte(8'($urandom));
            end
        end
        add_byte({3'($urandom), 4'($urandom), end_bit});
    endfunction

    function automatic void build_good(int n_rpt, int n_pay);
        frame_buf.delete();
        add_addr(1'($urandom));
        add_addr(n_rpt == 0);
        for (int i = 0; i < n_rpt; i++)
        begin
            add_addr(i == n_rpt - 1);
        end
        add_byte(CTRL_UI);
        add_byte(PID_NONE);
        for (int i = 0; i < n_pay; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_byte(8'($urandom));
            end
            else
            begin
                add_byte(8'($urandom_range(32, 126)));
            end
        end
    endfunction

    task automatic send_random_frame(frame_kind_t k);
        int n_rpt;
        int n_pay;
        int cut;
        n_rpt = $urandom_range(0, 3);
        n_pay = $urandom_range(0, 12);
        if (k == FR_NOISE)
        begin
            frame_buf.delete();
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
            cut = frame_buf.size();
        end
        else
        begin
            if (k == FR_CUT_RPT && n_rpt == 0)
            begin
                n_rpt = 1;
            end
            if (k == FR_EMPTY)
            begin
                n_pay = 0;
            end
            build_good(n_rpt, n_pay);
            cut = frame_buf.size();
            // control sits right after the address list, pid after it
            case (k)
                FR_CUT_RPT:  cut = 14 + $urandom_range(1, 7 * n_rpt);
                FR_CUT_ANY:  cut = $urandom_range(1, 15 + 7 * n_rpt);
                FR_BAD_CTRL: frame_buf[14 + 7 * n_rpt] = bad_byte(CTRL_UI);
                FR_BAD_PID:  frame_buf[15 + 7 * n_rpt] = bad_byte(PID_NONE);
                FR_CTRL_END:
                begin
                    cut = 15 + 7 * n_rpt;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        frame_buf[14 + 7 * n_rpt] = bad_byte(CTRL_UI);
                    end
                end
                default: ;
            endcase
        end
        send_frame(cut);
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return FR_GOOD;
        if (r < 68) return FR_EMPTY;
        if (r < 74) return FR_CUT_RPT;
        if (r < 80) return FR_BAD_CTRL;
        if (r < 86) return FR_BAD_PID;
        if (r < 90) return FR_CTRL_END;
        if (r < 95) return FR_NOISE;
        return FR_CUT_ANY;
    endfunction

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int frame_no;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        bytes_sent = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // dest chars: top char, lowest kept, 'Z', just above 'Z', space, zero;
        // ssid 15; full source; payload covers the printable edges
        frame_buf = '{8'hFF, 8'h42, 8'hB4, 8'hB6, 8'h40, 8'h00, 8'h1E,
                      8'h82, 8'h84, 8'h86, 8'h88, 8'h8A, 8'h8C, 8'h61,
                      8'h03, 8'hF0,
                      8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'hFF};
        send_frame(frame_buf.size());
        // frame that ends on its very first byte
        frame_buf = '{8'h55};
        send_frame(1);

        frame_no = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (frame_no == 2)
            begin
                hold_req = 1'b1;
            end
            quiet = (bytes_sent >= 250 && bytes_sent < 400);
            if (frame_no < 8)
            begin
                send_random_frame(frame_kind_t'(frame_no));
            end
            else
            begin
                send_random_frame(pick_kind());
            end
            frame_no++;
        end
        quiet = 1'b0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
